// ===== rtl/hbs_pkg.sv =====
`timescale 1ns / 1ps
package hbs_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 256;
  localparam int FRAC_BITS  = 16;
  localparam int CMD_DEPTH  = 4;
  localparam int RES_DEPTH  = 16;
  localparam int BANK_DEPTH = (MAX_COLS / 2) * (MAX_ROWS / 2);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH,
    CFG_GRID_HEIGHT,
    CFG_X_INV_SCALE,
    CFG_Y_INV_SCALE,
    CFG_X_OFFSET,
    CFG_Y_OFFSET,
    CFG_Z_SCALE
  } cfg_idx_t;

  typedef struct packed {
    logic [8:0]  grid_width;
    logic [8:0]  grid_height;
    logic [31:0] x_inv_scale;
    logic [31:0] y_inv_scale;
    logic [31:0] x_offset;
    logic [31:0] y_offset;
    logic [31:0] z_scale;
  } cfg_t;

  // Classified request between front and back
  typedef struct packed {
    logic        is_query;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] value;
    logic [15:0] fx;
    logic [15:0] fy;
    logic        xsat;
    logic        ysat;
    logic        outside;
    logic        single;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic [15:0] frac;
    logic        sat;
    logic        out;
  } axis_t;

  typedef struct packed {
    logic [47:0] height;
    logic [48:0] grad_x;
    logic [48:0] grad_y;
    logic        outside;
  } res_t;

  function automatic logic [47:0] sat48(input logic signed [51:0] x);
    logic [47:0] r;
    if (x[51:47] == 5'b00000 || x[51:47] == 5'b11111) r = x[47:0];
    else if (x[51]) r = {1'b1, 47'd0};
    else r = {1'b0, {47{1'b1}}};
    return r;
  endfunction

  function automatic logic [48:0] sat49(input logic signed [51:0] x);
    logic [48:0] r;
    if (x[51:48] == 4'b0000 || x[51:48] == 4'b1111) r = x[48:0];
    else if (x[51]) r = {1'b1, 48'd0};
    else r = {1'b0, {48{1'b1}}};
    return r;
  endfunction

endpackage

// ===== rtl/hbs_front.sv =====
`timescale 1ns / 1ps
module hbs_front import hbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               func,
  input  logic [7:0]         cell_col,
  input  logic [7:0]         cell_row,
  input  logic [15:0]        cell_value,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  cfg_t               cfg,
  output logic               cmd_valid,
  output cmd_t               cmd
);

  logic               v0_r;
  logic               q0_r;
  logic [7:0]         col0_r;
  logic [7:0]         row0_r;
  logic [15:0]        val0_r;
  logic signed [48:0] px0_r;
  logic signed [48:0] py0_r;
  logic signed [64:0] prod_x;
  logic signed [64:0] prod_y;
  logic signed [49:0] u;
  logic signed [49:0] v;
  logic [8:0]         w_eff;
  logic [8:0]         h_eff;
  axis_t              ax;
  axis_t              ay;
  cmd_t               cmd_nxt;
  logic               v1_r;
  cmd_t               cmd_r;

  // Clamp one axis to the grid and split it into cell index and fraction
  function automatic axis_t map_axis(input logic signed [49:0] p, input logic [8:0] n);
    axis_t              a;
    logic [8:0]         nm1;
    logic signed [49:0] hi;
    logic signed [49:0] lim;
    logic [24:0]        c;
    nm1 = n - 9'd1;
    hi  = $signed({25'd0, nm1, 16'd0});
    lim = $signed({25'd0, n, 16'd0});
    if (p < 0) c = '0;
    else if (p > hi) c = {nm1, 16'd0};
    else c = p[24:0];
    a.idx  = c[23:16];
    a.frac = c[15:0];
    a.sat  = (c[23:16] == nm1[7:0]);
    a.out  = (p < 0) || (p > lim);
    return a;
  endfunction

  // Scale the world position into grid units
  assign prod_x = $signed(pos_x) * $signed({1'b0, cfg.x_inv_scale});
  assign prod_y = $signed(pos_y) * $signed({1'b0, cfg.y_inv_scale});

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else v0_r <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q0_r   <= (func == FUNC_QUERY);
      col0_r <= cell_col;
      row0_r <= cell_row;
      val0_r <= cell_value;
      px0_r  <= prod_x[64:FRAC_BITS];
      py0_r  <= prod_y[64:FRAC_BITS];
    end
  end

  // Classify: offset, range check, clamp
  always_comb begin
    if (cfg.grid_width == 9'd0) w_eff = 9'd1;
    else if (cfg.grid_width > 9'(MAX_COLS)) w_eff = 9'(MAX_COLS);
    else w_eff = cfg.grid_width;
    if (cfg.grid_height == 9'd0) h_eff = 9'd1;
    else if (cfg.grid_height > 9'(MAX_ROWS)) h_eff = 9'(MAX_ROWS);
    else h_eff = cfg.grid_height;
    u  = $signed({px0_r[48], px0_r}) - $signed({{18{cfg.x_offset[31]}}, cfg.x_offset});
    v  = $signed({py0_r[48], py0_r}) - $signed({{18{cfg.y_offset[31]}}, cfg.y_offset});
    ax = map_axis(u, w_eff);
    ay = map_axis(v, h_eff);
    cmd_nxt.is_query = q0_r;
    cmd_nxt.col      = q0_r ? ax.idx : col0_r;
    cmd_nxt.row      = q0_r ? ay.idx : row0_r;
    cmd_nxt.value    = val0_r;
    cmd_nxt.fx       = ax.frac;
    cmd_nxt.fy       = ay.frac;
    cmd_nxt.xsat     = ax.sat;
    cmd_nxt.ysat     = ay.sat;
    cmd_nxt.outside  = ax.out || ay.out;
    cmd_nxt.single   = (w_eff == 9'd1) && (h_eff == 9'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
  end

  always_ff @(posedge clk) begin
    if (v0_r) cmd_r <= cmd_nxt;
  end

  assign cmd_valid = v1_r;
  assign cmd       = cmd_r;

endmodule

// ===== rtl/hbs_cmd_queue.sv =====
`timescale 1ns / 1ps
module hbs_cmd_queue import hbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cmd_t       wr_data,
  input  logic       rd_en,
  output cmd_t       rd_data,
  output logic [2:0] count
);

  cmd_t       entry_r [CMD_DEPTH];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] count_r;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 2'd1;
      count_r <= count_r + 3'(wr_en) - 3'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entry_r[wr_ptr_r] <= wr_data;
  end

  assign rd_data = entry_r[rd_ptr_r];
  assign count   = count_r;

endmodule

// ===== rtl/hbs_res_queue.sv =====
`timescale 1ns / 1ps
module hbs_res_queue import hbs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  res_t       wr_data,
  input  logic       rd_en,
  output res_t       rd_data,
  output logic [4:0] count
);

  res_t       entry_r [RES_DEPTH];
  logic [3:0] wr_ptr_r;
  logic [3:0] rd_ptr_r;
  logic [4:0] count_r;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 4'd1;
      if (rd_en) rd_ptr_r <= rd_ptr_r + 4'd1;
      count_r <= count_r + 5'(wr_en) - 5'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) entry_r[wr_ptr_r] <= wr_data;
  end

  assign rd_data = entry_r[rd_ptr_r];
  assign count   = count_r;

endmodule

// ===== rtl/hbs_back.sv =====
`timescale 1ns / 1ps
module hbs_back import hbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output logic res_valid,
  output res_t res,
  output logic load_done
);

  logic [15:0]        rd_q_r [4];
  logic [13:0]        rd_addr [4];
  logic [13:0]        wr_addr;
  logic [1:0]         wr_bank;
  logic               wr_en;
  logic [7:0]         col_sel;
  logic [7:0]         row_sel;

  logic               v1_r;
  cmd_t               c1_r;
  logic               i0p;
  logic               j0p;
  logic               c1p;
  logic               r1p;

  logic               v2_r, q2_r, out2_r, sgl2_r;
  logic [15:0]        h00_2_r, h10_2_r, h01_2_r, h11_2_r, fx2_r, fy2_r;

  logic [16:0]        ofx2;
  logic [16:0]        ofy2;
  logic signed [16:0] dh10, dh11y, dh01, dh11x;
  logic               v3_r, q3_r, out3_r, sgl3_r;
  logic [15:0]        h00_3_r, fy3_r;
  logic [32:0]        p00_r, p10_r, p01_r, p11_r;
  logic signed [34:0] dx0_r, dx1_r, dy0_r, dy1_r;

  logic               v4_r, q4_r, out4_r, sgl4_r;
  logic [15:0]        h00_4_r, fy4_r;
  logic [32:0]        a0_r, a1_r;
  logic signed [35:0] ex4_r, ey4_r;

  logic [16:0]        ofy4;
  logic [50:0]        s_sum;
  logic               v5_r, q5_r, out5_r, sgl5_r;
  logic [15:0]        h00_5_r;
  logic [34:0]        sh5_r;
  logic signed [35:0] ex5_r, ey5_r;

  logic signed [67:0] hp;
  logic signed [67:0] gxp;
  logic signed [67:0] gyp;
  logic               v6_r, q6_r, out6_r, sgl6_r;
  logic [15:0]        h00_6_r;
  logic signed [51:0] hs6_r, gx6_r, gy6_r;

  // Bank addresses: banks split by column and row parity
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      col_sel    = (cmd.col[0] == b[0]) ? cmd.col : cmd.col + 8'd1;
      row_sel    = (cmd.row[0] == b[1]) ? cmd.row : cmd.row + 8'd1;
      rd_addr[b] = {row_sel[7:1], col_sel[7:1]};
    end
  end

  assign wr_en   = start && !cmd.is_query;
  assign wr_bank = {cmd.row[0], cmd.col[0]};
  assign wr_addr = {cmd.row[7:1], cmd.col[7:1]};

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [15:0] mem [BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (wr_en && wr_bank == 2'(b)) mem[wr_addr] <= cmd.value;
      rd_q_r[b] <= mem[rd_addr[b]];
    end
  end

  // Stage 1: hold the request beside the read data
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= start;
  end

  always_ff @(posedge clk) begin
    if (start) c1_r <= cmd;
  end

  // Route bank data to the four corners; a saturated neighbor reuses the base cell
  assign i0p = c1_r.col[0];
  assign j0p = c1_r.row[0];
  assign c1p = c1_r.xsat ? i0p : ~i0p;
  assign r1p = c1_r.ysat ? j0p : ~j0p;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    q2_r    <= c1_r.is_query;
    out2_r  <= c1_r.outside;
    sgl2_r  <= c1_r.single;
    fx2_r   <= c1_r.fx;
    fy2_r   <= c1_r.fy;
    h00_2_r <= rd_q_r[{j0p, i0p}];
    h10_2_r <= rd_q_r[{j0p, c1p}];
    h01_2_r <= rd_q_r[{r1p, i0p}];
    h11_2_r <= rd_q_r[{r1p, c1p}];
  end

  // Stage 3: weighted corner products and difference products
  assign ofx2  = 17'h10000 - {1'b0, fx2_r};
  assign ofy2  = 17'h10000 - {1'b0, fy2_r};
  assign dh10  = $signed({1'b0, h10_2_r}) - $signed({1'b0, h00_2_r});
  assign dh11y = $signed({1'b0, h11_2_r}) - $signed({1'b0, h01_2_r});
  assign dh01  = $signed({1'b0, h01_2_r}) - $signed({1'b0, h00_2_r});
  assign dh11x = $signed({1'b0, h11_2_r}) - $signed({1'b0, h10_2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    q3_r    <= q2_r;
    out3_r  <= out2_r;
    sgl3_r  <= sgl2_r;
    h00_3_r <= h00_2_r;
    fy3_r   <= fy2_r;
    p00_r   <= h00_2_r * ofx2;
    p10_r   <= h10_2_r * fx2_r;
    p01_r   <= h01_2_r * ofx2;
    p11_r   <= h11_2_r * fx2_r;
    dx0_r   <= dh10 * $signed({1'b0, ofy2});
    dx1_r   <= dh11y * $signed({1'b0, 1'b0, fy2_r});
    dy0_r   <= dh01 * $signed({1'b0, ofx2});
    dy1_r   <= dh11x * $signed({1'b0, 1'b0, fx2_r});
  end

  // Stage 4: row blends and raw gradients
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    q4_r    <= q3_r;
    out4_r  <= out3_r;
    sgl4_r  <= sgl3_r;
    h00_4_r <= h00_3_r;
    fy4_r   <= fy3_r;
    a0_r    <= p00_r + p10_r;
    a1_r    <= p01_r + p11_r;
    ex4_r   <= dx0_r + dx1_r;
    ey4_r   <= dy0_r + dy1_r;
  end

  // Stage 5: column blend, drop the fraction
  assign ofy4  = 17'h10000 - {1'b0, fy4_r};
  assign s_sum = a0_r * ofy4 + a1_r * fy4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    q5_r    <= q4_r;
    out5_r  <= out4_r;
    sgl5_r  <= sgl4_r;
    h00_5_r <= h00_4_r;
    sh5_r   <= s_sum[50:FRAC_BITS];
    ex5_r   <= ex4_r;
    ey5_r   <= ey4_r;
  end

  // Stage 6: apply z scale
  assign hp  = $signed({1'b0, sh5_r}) * $signed(cfg.z_scale);
  assign gxp = ex5_r * $signed(cfg.z_scale);
  assign gyp = ey5_r * $signed(cfg.z_scale);

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    q6_r    <= q5_r;
    out6_r  <= out5_r;
    sgl6_r  <= sgl5_r;
    h00_6_r <= h00_5_r;
    hs6_r   <= hp[67:FRAC_BITS];
    gx6_r   <= gxp[67:FRAC_BITS];
    gy6_r   <= gyp[67:FRAC_BITS];
  end

  // Saturate and pick the special cases
  always_comb begin
    res.height  = sgl6_r ? {16'd0, h00_6_r, 16'd0} : sat48(hs6_r);
    res.grad_x  = out6_r ? '0 : sat49(gx6_r);
    res.grad_y  = out6_r ? '0 : sat49(gy6_r);
    res.outside = out6_r;
  end

  assign res_valid = v6_r && q6_r;
  assign load_done = v6_r && !q6_r;

endmodule

// ===== rtl/heightmap_bilinear_sampler_unit.sv =====
`timescale 1ns / 1ps
// Bilinear height-map sampler. Load requests write one 16-bit cell of a 256x256 grid;
// query requests map a Q16.16 world position into grid units, clamp it, and return the
// interpolated height and x/y gradients scaled by z_scale, with gradients zeroed and
// outside set when the position lies off the grid. One request is taken per clock
// cycle while full is low; the grid sits in four banks split by column and row parity,
// so the four corner cells of a query come out of one read each. A query's result
// passes two front stages, the command queue and six back stages before it enters
// the result queue. Loads and queries are processed in order, so a query sees every
// earlier load. Reading a cell that was never loaded returns an undefined value.
// Configuration must be written only while no request is in flight; not enforced.
module heightmap_bilinear_sampler_unit import hbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_func,
  input  logic [7:0]         in_cell_col,
  input  logic [7:0]         in_cell_row,
  input  logic [15:0]        in_cell_value,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  output logic               empty,
  input  logic               pop,
  output logic signed [47:0] out_height_out,
  output logic signed [48:0] out_grad_x,
  output logic signed [48:0] out_grad_y,
  output logic               out_outside,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t       cfg_r;
  logic       accept;
  logic       cmd_valid;
  cmd_t       cmd_front;
  cmd_t       cmd_head;
  logic [2:0] qcnt;
  logic       cmd_pop;
  logic       res_valid;
  res_t       res;
  res_t       res_head;
  logic       load_done;
  logic [4:0] ocnt;
  logic       out_pop;
  logic [2:0] fcnt_r;
  logic [2:0] fcnt_nxt;
  logic [4:0] bcnt_r;
  logic [4:0] bcnt_nxt;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width  <= 9'd1;
      cfg_r.grid_height <= 9'd1;
      cfg_r.x_inv_scale <= 32'h0001_0000;
      cfg_r.y_inv_scale <= 32'h0001_0000;
      cfg_r.x_offset    <= '0;
      cfg_r.y_offset    <= '0;
      cfg_r.z_scale     <= 32'h0001_0000;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_GRID_WIDTH:  cfg_r.grid_width  <= cfg_data[8:0];
        CFG_GRID_HEIGHT: cfg_r.grid_height <= cfg_data[8:0];
        CFG_X_INV_SCALE: cfg_r.x_inv_scale <= cfg_data;
        CFG_Y_INV_SCALE: cfg_r.y_inv_scale <= cfg_data;
        CFG_X_OFFSET:    cfg_r.x_offset    <= cfg_data;
        CFG_Y_OFFSET:    cfg_r.y_offset    <= cfg_data;
        CFG_Z_SCALE:     cfg_r.z_scale     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front credits cover the two front stages and the command queue
  assign full     = (fcnt_r == 3'(CMD_DEPTH));
  assign accept   = push && !full;
  // Back credits cover the back stages and the result queue
  assign cmd_pop  = (qcnt != 3'd0) && (bcnt_r < 5'(RES_DEPTH));
  assign empty    = (ocnt == 5'd0);
  assign out_pop  = pop && !empty;
  assign fcnt_nxt = fcnt_r + 3'(accept) - 3'(cmd_pop);
  assign bcnt_nxt = bcnt_r + 5'(cmd_pop) - 5'(out_pop) - 5'(load_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcnt_r <= '0;
      bcnt_r <= '0;
    end else begin
      fcnt_r <= fcnt_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  hbs_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .func       (in_func),
    .cell_col   (in_cell_col),
    .cell_row   (in_cell_row),
    .cell_value (in_cell_value),
    .pos_x      (in_pos_x),
    .pos_y      (in_pos_y),
    .cfg        (cfg_r),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_front)
  );

  hbs_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_valid),
    .wr_data (cmd_front),
    .rd_en   (cmd_pop),
    .rd_data (cmd_head),
    .count   (qcnt)
  );

  hbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd_pop),
    .cmd       (cmd_head),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res),
    .load_done (load_done)
  );

  hbs_res_queue u_res_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_valid),
    .wr_data (res),
    .rd_en   (out_pop),
    .rd_data (res_head),
    .count   (ocnt)
  );

  assign out_height_out = res_head.height;
  assign out_grad_x     = res_head.grad_x;
  assign out_grad_y     = res_head.grad_y;
  assign out_outside    = res_head.outside;

  // Credit bookkeeping checks
  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= 3'(CMD_DEPTH))
    else $error("front credit count exceeds queue depth");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt <= fcnt_r)
    else $error("command queue holds more than front credits");

  a_res_in_credit: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt <= bcnt_r)
    else $error("result queue holds more than back credits");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (ocnt < 5'(RES_DEPTH) || out_pop))
    else $error("result pushed into a full result queue");

endmodule
